// File: src/etb_pkg.sv
// Shared types and constants for the event timeout bank.
// Used by etb_core and event_timeout_bank_top; no other dependencies.
package etb_pkg;

  localparam int unsigned SLOT_LIMIT      = 8;
  localparam int unsigned EVENT_SLOTS_DEF = 8;
  localparam int unsigned MASK_W          = 8;
  localparam int unsigned TIMEOUT_W       = 32;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ARM   = 2'd1,
    CMD_SET   = 2'd2,
    CMD_CLEAR = 2'd3
  } etb_op_t;

  typedef struct packed {
    etb_op_t               op;
    logic [MASK_W-1:0]     event_mask;
    logic [TIMEOUT_W-1:0]  timeout;
  } etb_item_t;

endpackage

// File: src/etb_core.sv
// Slot state of the event timeout bank: countdown counters and pending flags.
// Applies one registered command per fire strobe; depends on etb_pkg.
module etb_core import etb_pkg::*; #(
  parameter int unsigned EVENT_SLOTS = EVENT_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  etb_item_t         item,
  output logic [MASK_W-1:0] flags_nxt
);

  localparam logic [MASK_W-1:0] SLOT_BITS = MASK_W'((1 << EVENT_SLOTS) - 1);

  logic [TIMEOUT_W-1:0] cnt_r   [EVENT_SLOTS];
  logic [TIMEOUT_W-1:0] cnt_nxt [EVENT_SLOTS];
  logic [MASK_W-1:0]    flags_r;
  logic [MASK_W-1:0]    mask;
  logic [MASK_W-1:0]    fire_vec;
  logic [EVENT_SLOTS-1:0] low_sel;
  logic [EVENT_SLOTS-1:0] slot_fire;
  logic                 one_hot;
  logic                 tmo_nz;

  assign mask    = item.event_mask & SLOT_BITS;
  assign one_hot = (mask != '0) && ((mask & (mask - MASK_W'(1))) == '0);
  assign tmo_nz  = (item.timeout != '0);

  // Clear stops only the lowest-numbered masked slot.
  always_comb begin
    logic found;
    found   = 1'b0;
    low_sel = '0;
    for (int i = 0; i < EVENT_SLOTS; i++) begin
      if (!found && mask[i]) begin
        low_sel[i] = 1'b1;
        found      = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < EVENT_SLOTS; g++) begin : g_slot
    always_comb begin
      cnt_nxt[g]   = cnt_r[g];
      slot_fire[g] = 1'b0;
      unique case (item.op)
        CMD_TICK: begin
          if (cnt_r[g] != '0) begin
            cnt_nxt[g]   = cnt_r[g] - TIMEOUT_W'(1);
            slot_fire[g] = (cnt_r[g] == TIMEOUT_W'(1));
          end
        end
        CMD_ARM: begin
          if (tmo_nz && one_hot && mask[g]) cnt_nxt[g] = item.timeout;
        end
        CMD_SET: begin
          if (mask[g]) cnt_nxt[g] = '0;
        end
        CMD_CLEAR: begin
          if (low_sel[g]) cnt_nxt[g] = '0;
        end
        default: cnt_nxt[g] = cnt_r[g];
      endcase
    end
  end

  always_comb begin
    fire_vec = '0;
    for (int i = 0; i < EVENT_SLOTS; i++) fire_vec[i] = slot_fire[i];
  end

  always_comb begin
    logic [MASK_W-1:0] f;
    unique case (item.op)
      CMD_TICK:  f = flags_r | fire_vec;
      CMD_ARM:   f = flags_r & ~mask;
      CMD_SET:   f = flags_r | mask;
      CMD_CLEAR: f = flags_r & ~mask;
      default:   f = flags_r;
    endcase
    flags_nxt = f & SLOT_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      for (int i = 0; i < EVENT_SLOTS; i++) cnt_r[i] <= '0;
    end else if (fire) begin
      flags_r <= flags_nxt;
      for (int i = 0; i < EVENT_SLOTS; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

  a_unimpl_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r & ~SLOT_BITS) == '0)
    else $error("flag raised on an unimplemented slot");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(flags_r))
    else $error("flags changed without a command");

  a_set_raises: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == CMD_SET |=> (flags_r & $past(mask)) == $past(mask))
    else $error("set did not raise masked flags");

  a_arm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.op == CMD_ARM |=> (flags_r & $past(mask)) == '0)
    else $error("arm did not clear masked flags");

endmodule

// File: src/event_timeout_bank_top.sv
// Top level of the event timeout bank: input register, slot core, result register.
// Depends on etb_pkg and etb_core.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   in_command, in_event_mask, in_timeout
//   out      out  out_valid/out_stall out_pending_events
//
// One beat in, one beat out; a beat can be taken every cycle while in is not stalled.
// A beat passes through the input register, then the result register,
// with the counter and flag update done combinationally in between.
// Reset (rst_n low, synchronous) stops all counters and clears all flags.
// A stall on out holds the result; in stalls only when both registers are full.
module event_timeout_bank_top import etb_pkg::*; #(
  parameter int unsigned EVENT_SLOTS = EVENT_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [MASK_W-1:0]    in_event_mask,
  input  logic [TIMEOUT_W-1:0] in_timeout,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MASK_W-1:0]    out_pending_events
);

  etb_item_t         item_r;
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic [MASK_W-1:0] out_pe_r;
  logic [MASK_W-1:0] flags_nxt;
  logic              out_can;
  logic              fire;
  logic              in_acc;

  assign out_can  = !out_vld_r || !out_stall;
  assign fire     = s1_vld_r && out_can;
  assign in_stall = s1_vld_r && !out_can;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    priority if (in_acc) s1_vld_nxt = 1'b1;
    else if (fire)       s1_vld_nxt = 1'b0;
    else                 s1_vld_nxt = s1_vld_r;
  end

  always_comb begin
    priority if (fire)  out_vld_nxt = 1'b1;
    else if (!out_stall) out_vld_nxt = 1'b0;
    else                 out_vld_nxt = out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: the item loads on accept, the result on fire; both hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.op         <= etb_op_t'(in_command);
      item_r.event_mask <= in_event_mask;
      item_r.timeout    <= in_timeout;
    end
    if (fire) out_pe_r <= flags_nxt;
  end

  etb_core #(
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .flags_nxt (flags_nxt)
  );

  assign out_valid          = out_vld_r;
  assign out_pending_events = out_pe_r;

endmodule

// File: bench/event_timeout_bank_top_test.sv
// Self-checking bench for event_timeout_bank_top: directed and random commands
// against an in-bench slot and flag predictor, with random idling on both channels.
// Depends on etb_pkg and the event_timeout_bank_top RTL.
`timescale 1ns / 1ps

module event_timeout_bank_top_test;
  import etb_pkg::*;

  localparam int unsigned SLOTS       = EVENT_SLOTS_DEF;
  localparam logic [MASK_W-1:0] SLOT_BITS =
    (SLOTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << SLOTS) - 1);
  localparam int unsigned RANDOM_CMDS = 1500;
  localparam int unsigned LONG_HOLD_AT = 300;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned IDLE_LIMIT   = 3000;

  typedef struct {
    etb_op_t               op;
    logic [MASK_W-1:0]     mask;
    logic [TIMEOUT_W-1:0]  ticks;
    bit                    drain;
  } bank_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_command = CMD_TICK;
  logic [MASK_W-1:0]    in_event_mask = '0;
  logic [TIMEOUT_W-1:0] in_timeout = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MASK_W-1:0]    out_pending_events;

  event_timeout_bank_top #(.EVENT_SLOTS(SLOTS)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_event_mask      (in_event_mask),
    .in_timeout         (in_timeout),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pending_events (out_pending_events)
  );

  // predicted bank state
  logic [TIMEOUT_W-1:0] slot_countdown [SLOT_LIMIT];
  logic [MASK_W-1:0]    slot_pending;

  bank_cmd_t         cmd_queue [$];
  logic [MASK_W-1:0] expected_flags [$];
  int unsigned       total_cmds = 0;
  int unsigned       beats_in = 0;
  int unsigned       beats_out = 0;
  int unsigned       send_wait = 0;
  int unsigned       hold_left = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       errors = 0;
  bit                tx_burst = 1'b0;
  bit                rx_burst = 1'b0;

  // Apply one command to the predicted bank and return the new flag vector.
  function automatic logic [MASK_W-1:0] step_bank(etb_op_t op, logic [MASK_W-1:0] mask_in,
                                                  logic [TIMEOUT_W-1:0] ticks);
    logic [MASK_W-1:0] m;
    logic [MASK_W-1:0] f;
    bit                done;
    m = mask_in & SLOT_BITS;
    f = slot_pending;
    done = 1'b0;
    case (op)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_countdown[i] != '0) begin
            slot_countdown[i] = slot_countdown[i] - 1'b1;
            if (slot_countdown[i] == '0) f[i] = 1'b1;
          end
        end
      end
      CMD_ARM: begin
        f = f & ~m;
        if (ticks != '0 && m != '0 && (m & (m - 1'b1)) == '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (m[i]) slot_countdown[i] = ticks;
          end
        end
      end
      CMD_SET: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (m[i]) slot_countdown[i] = '0;
        end
        f = f | m;
      end
      default: begin
        // only the lowest masked slot loses its counter
        for (int i = 0; i < SLOTS; i++) begin
          if (m[i] && !done) begin
            slot_countdown[i] = '0;
            done = 1'b1;
          end
        end
        f = f & ~m;
      end
    endcase
    slot_pending = f & SLOT_BITS;
    return slot_pending;
  endfunction

  task automatic queue_cmd(etb_op_t op, logic [MASK_W-1:0] mask, logic [TIMEOUT_W-1:0] ticks,
                           bit drain = 1'b0);
    bank_cmd_t c;
    c.op = op;
    c.mask = mask;
    c.ticks = ticks;
    c.drain = drain;
    cmd_queue.push_back(c);
    total_cmds++;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // driver: present queued commands, predict each accepted beat
  always @(posedge clk) begin
    bank_cmd_t   c;
    logic        took;
    int unsigned w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
      beats_in <= 0;
    end else begin
      took = in_valid && !in_stall;
      w = send_wait;
      if (took) begin
        expected_flags.push_back(step_bank(etb_op_t'(in_command), in_event_mask, in_timeout));
        beats_in <= beats_in + 1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        w = tx_burst ? 0 : $urandom_range(0, 17);
      end
      if (!in_valid || took) begin
        if (w != 0) begin
          w--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain && (took || beats_out != beats_in))) begin
          c = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_command <= c.op;
          in_event_mask <= c.mask;
          in_timeout <= c.ticks;
        end else begin
          in_valid <= 1'b0;
        end
      end
      send_wait <= w;
    end
  end

  // monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    logic [MASK_W-1:0] want;
    int unsigned       h;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      beats_out <= 0;
    end else begin
      h = hold_left;
      if (out_valid && !out_stall) begin
        if (beats_out >= beats_in) begin
          $display("%0t: unexpected result, expected none actual %02h", $time,
                   out_pending_events);
          errors++;
        end else begin
          want = expected_flags[beats_out];
          if (out_pending_events !== want) begin
            $display("%0t: pending_events mismatch, expected %02h actual %02h", $time,
                     want, out_pending_events);
            errors++;
          end
        end
        beats_out <= beats_out + 1;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        h = rx_burst ? 0 : $urandom_range(0, 17);
        // hold off long enough for the block to back up into its input
        if (beats_out == LONG_HOLD_AT) h = LONG_HOLD;
      end
      if (h != 0) begin
        out_stall <= 1'b1;
        h--;
      end else begin
        out_stall <= 1'b0;
      end
      hold_left <= h;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned r;
    logic [MASK_W-1:0]    m;
    logic [TIMEOUT_W-1:0] t;
    for (int i = 0; i < SLOT_LIMIT; i++) slot_countdown[i] = '0;
    slot_pending = '0;

    // directed: firing, reload, no-bit and multi-bit arm, zero timeout,
    // empty clear, clear that stops only its lowest slot
    queue_cmd(CMD_TICK, 8'h00, 32'h0);
    queue_cmd(CMD_ARM, 8'h01, 32'd1);
    queue_cmd(CMD_TICK, 8'h00, 32'h0);
    queue_cmd(CMD_ARM, 8'h80, 32'd3);
    queue_cmd(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_TICK, 8'h00, 32'h0);
    queue_cmd(CMD_TICK, 8'h00, 32'h0);
    queue_cmd(CMD_ARM, 8'h00, 32'd5);
    queue_cmd(CMD_ARM, 8'h18, 32'd7);
    queue_cmd(CMD_ARM, 8'h04, 32'd0);
    queue_cmd(CMD_ARM, 8'h04, 32'd2);
    queue_cmd(CMD_ARM, 8'h04, 32'hFFFF_FFFF);
    queue_cmd(CMD_TICK, 8'h00, 32'h0);
    queue_cmd(CMD_SET, 8'hFF, 32'h0);
    queue_cmd(CMD_CLEAR, 8'h00, 32'h0);
    queue_cmd(CMD_ARM, 8'h02, 32'd2);
    queue_cmd(CMD_ARM, 8'h20, 32'd2);
    queue_cmd(CMD_CLEAR, 8'h22, 32'h0);
    queue_cmd(CMD_TICK, 8'h00, 32'h0);
    queue_cmd(CMD_TICK, 8'h00, 32'h0);
    queue_cmd(CMD_ARM, 8'h01, 32'hAAAA_AAAA);
    queue_cmd(CMD_ARM, 8'h40, 32'h5555_5555);
    queue_cmd(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_SET, 8'h0F, 32'h0);

    // random: mostly single-slot arms with short timeouts and plenty of ticks
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      m = MASK_W'($urandom);
      t = $urandom;
      if (r < 45) begin
        queue_cmd(CMD_TICK, m, t, n == 500 || n == 1100);
      end else if (r < 75) begin
        if ($urandom_range(0, 9) != 0) m = 8'h01 << $urandom_range(0, MASK_W - 1);
        r = $urandom_range(0, 9);
        if (r < 8) t = $urandom_range(1, 24);
        else if (r == 8) t = '0;
        queue_cmd(CMD_ARM, m, t, n == 500 || n == 1100);
      end else if (r < 85) begin
        m = m & MASK_W'($urandom);
        queue_cmd(CMD_SET, m, t, n == 500 || n == 1100);
      end else begin
        if ($urandom_range(0, 1) == 0) m = 8'h01 << $urandom_range(0, MASK_W - 1);
        queue_cmd(CMD_CLEAR, m, t, n == 500 || n == 1100);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_in != total_cmds || beats_out != total_cmds) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && beats_out == beats_in) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
src/etb_pkg.sv
src/etb_core.sv
src/event_timeout_bank_top.sv
bench/event_timeout_bank_top_test.sv
